@@ sv/fspc_pkg.sv @@
// ----------------------------------------------------------------------------
// fspc_pkg: shared types and constants of the frame stream pattern checker
// Holds the frame parse phases, error codes and the state/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fspc_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PAD     = 2'd2
  } fspc_phase_t;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_FRAME   = 3'd1;
  localparam logic [2:0] ERR_COUNT   = 3'd2;
  localparam logic [2:0] ERR_SOURCE  = 3'd3;
  localparam logic [2:0] ERR_CONTENT = 3'd4;
  localparam logic [2:0] ERR_SEQ     = 3'd5;

  localparam logic [0:0] CFG_PATTERN_ID  = 1'b0;
  localparam logic [0:0] CFG_PATTERN_VER = 1'b1;

  localparam logic [7:0] PATTERN_MARK  = 8'hbc;
  localparam logic [7:0] MIN_FRAME_CNT = 8'd4;
  localparam logic [7:0] MAX_FRAME_CNT = 8'd64;

  // Per-block parse state (the word counter lives in the top level, its
  // width follows the length parameter)
  typedef struct packed {
    logic [7:0]  last_fn;
    logic [15:0] last_seq;
    fspc_phase_t phase;
    logic [6:0]  frame_words;
    logic [6:0]  word_index;
    logic [1:0]  pad_left;
    logic        pattern_on;
    logic [2:0]  err;
  } fspc_state_t;

  typedef struct packed {
    logic       valid;
    logic       pass;
    logic [2:0] code;
  } fspc_result_t;

endpackage

`default_nettype wire

@@ sv/fspc_step.sv @@
// ----------------------------------------------------------------------------
// fspc_step: per-word check logic
// Computes the next parse state and the block result for one payload word.
// ----------------------------------------------------------------------------
`default_nettype none

module fspc_step #(
  parameter int LENGTH_WIDTH = 16
) (
  input  fspc_pkg::fspc_state_t  st,
  input  logic [LENGTH_WIDTH-1:0] words_left,
  input  logic [15:0]             word,
  input  logic                    first,
  input  logic [LENGTH_WIDTH-1:0] block_words,
  input  logic [7:0]              sys_id,
  input  logic [7:0]              sys_ver,
  input  logic [7:0]              cfg_id,
  input  logic [7:0]              cfg_ver,
  output fspc_pkg::fspc_state_t  st_next,
  output logic [LENGTH_WIDTH-1:0] words_left_next,
  output fspc_pkg::fspc_result_t res
);
  import fspc_pkg::*;

  localparam int CW = LENGTH_WIDTH + 1;

  fspc_state_t             s;
  logic [LENGTH_WIDTH-1:0] wl;
  logic [LENGTH_WIDTH-1:0] wl_dec;
  logic [7:0]              num;
  logic [7:0]              cnt;
  logic [1:0]              pad;
  logic [CW-1:0]           need;
  logic [7:0]              idx_inc;
  logic [7:0]              idx_dec;
  logic                    hdr_ok_fn;
  logic                    last_word;

  assign num     = word[15:8];
  assign cnt     = word[7:0] + 8'd1;
  // header plus content padded to a multiple of four
  assign pad     = ~cnt[1:0];
  assign idx_inc = {1'b0, st.word_index} + 8'd1;
  assign idx_dec = {1'b0, st.word_index} - 8'd1;
  assign last_word = (idx_inc >= {1'b0, st.frame_words});

  always_comb begin
    s         = st;
    wl        = words_left;
    res       = '0;
    wl_dec    = '0;
    need      = '0;
    hdr_ok_fn = 1'b0;
    if (first) begin
      wl           = block_words;
      s.pattern_on = (sys_id == cfg_id) && (sys_ver == cfg_ver);
      s.err        = ERR_NONE;
      s.phase      = PH_HEADER;
      s.frame_words = '0;
      s.word_index = '0;
      s.pad_left   = '0;
    end
    if (first && block_words == '0) begin
      // empty block: report clean at once, word not examined
      res.valid = 1'b1;
      res.pass  = 1'b1;
      res.code  = ERR_NONE;
    end else if (wl != '0) begin
      wl_dec = wl - LENGTH_WIDTH'(1);
      wl     = wl_dec;
      if (s.err == ERR_NONE) begin
        unique case (s.phase)
          PH_CONTENT: begin
            if (s.pattern_on && st.word_index == 7'd0) begin
              if (word != 16'd0) s.err = ERR_SOURCE;
            end else if (s.pattern_on && !last_word) begin
              if (word[15:8] != PATTERN_MARK || word[7:0] != idx_dec) s.err = ERR_CONTENT;
            end else if (s.pattern_on) begin
              if (st.last_seq != 16'd0 && word != st.last_seq + 16'd1) s.err = ERR_SEQ;
              else s.last_seq = word;
            end
            if (s.err == ERR_NONE) begin
              s.word_index = idx_inc[6:0];
              if (last_word) s.phase = (st.pad_left != 2'd0) ? PH_PAD : PH_HEADER;
            end
          end
          PH_PAD: begin
            s.pad_left = st.pad_left - 2'd1;
            if (s.pad_left == 2'd0) s.phase = PH_HEADER;
          end
          default: begin
            hdr_ok_fn = (st.last_fn == 8'd0) || (num == st.last_fn + 8'd1);
            need      = CW'(cnt) + CW'(pad);
            if (!hdr_ok_fn) begin
              s.err = ERR_FRAME;
            end else begin
              s.last_fn = num;
              if (cnt < MIN_FRAME_CNT || cnt > MAX_FRAME_CNT || need > {1'b0, wl_dec}) begin
                s.err = ERR_COUNT;
              end else begin
                s.frame_words = cnt[6:0];
                s.word_index  = '0;
                s.pad_left    = pad;
                s.phase       = PH_CONTENT;
              end
            end
          end
        endcase
      end
      if (wl_dec == '0) begin
        res.valid = 1'b1;
        res.pass  = (s.err == ERR_NONE);
        res.code  = s.err;
      end
    end
    st_next         = s;
    words_left_next = wl;
  end

endmodule

`default_nettype wire

@@ sv/frame_stream_pattern_checker_core.sv @@
// ----------------------------------------------------------------------------
// frame_stream_pattern_checker_core: block/frame stream checker
// Checks frame numbering, frame sizes and generator pattern content of the
// payload words of a data block; gives one pass/error result per block.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid/in_ready, word, first, block_words,  | in
//          | sys_id, sys_ver                              |
//  result  | out_valid/out_ready, pass, error_code        | out
//  config  | cfg_wr_en, cfg_index, cfg_data               | in
//
//  One word per cycle while the result is not stalled. A word passes an
//  input register, then the check logic updates the parse state and, on
//  the block's last word (or an empty block), loads the result register,
//  which holds the result until it transfers. Reset clears all parse
//  state, both config registers and both valid flags. A stalled result
//  holds the input register; while the result waits the input side takes
//  at most one more word, into an empty input register, then stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_stream_pattern_checker_core #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             word,
  input  logic                    first,
  input  logic [LENGTH_WIDTH-1:0] block_words,
  input  logic [7:0]              sys_id,
  input  logic [7:0]              sys_ver,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    pass,
  output logic [2:0]              error_code,
  // configuration write port
  input  logic                    cfg_wr_en,
  input  logic [0:0]              cfg_index,
  input  logic [7:0]              cfg_data
);
  import fspc_pkg::*;

  // configuration
  logic [7:0] cfg_id;
  logic [7:0] cfg_ver;

  // input register
  logic                    s1_valid;
  logic [15:0]             s1_word;
  logic                    s1_first;
  logic [LENGTH_WIDTH-1:0] s1_block_words;
  logic [7:0]              s1_sys_id;
  logic [7:0]              s1_sys_ver;

  // parse state
  fspc_state_t             st;
  fspc_state_t             st_next;
  logic [LENGTH_WIDTH-1:0] words_left;
  logic [LENGTH_WIDTH-1:0] words_left_next;
  fspc_result_t            res;

  logic s1_fire;
  logic in_xfer;

  // advance the input register whenever the result register can take a value
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_id  <= '0;
      cfg_ver <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PATTERN_ID:  cfg_id  <= cfg_data;
        CFG_PATTERN_VER: cfg_ver <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // payload of the input register, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_word        <= word;
      s1_first       <= first;
      s1_block_words <= block_words;
      s1_sys_id      <= sys_id;
      s1_sys_ver     <= sys_ver;
    end
  end

  fspc_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .st              (st),
    .words_left      (words_left),
    .word            (s1_word),
    .first           (s1_first),
    .block_words     (s1_block_words),
    .sys_id          (s1_sys_id),
    .sys_ver         (s1_sys_ver),
    .cfg_id          (cfg_id),
    .cfg_ver         (cfg_ver),
    .st_next         (st_next),
    .words_left_next (words_left_next),
    .res             (res)
  );

  // parse state advances once per word leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '{phase: PH_HEADER, default: '0};
      words_left <= '0;
    end else if (s1_fire) begin
      st         <= st_next;
      words_left <= words_left_next;
    end
  end

  // result register: load on a finishing word, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      pass       <= res.pass;
      error_code <= res.code;
    end
  end

endmodule

`default_nettype wire

@@ sv/fspc_checker.sv @@
// ----------------------------------------------------------------------------
// fspc_checker: port-level checks of the frame stream pattern checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module fspc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       pass,
  input logic [2:0] error_code
);
  import fspc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pass) && $stable(error_code))
    else $error("result changed while stalled");

  a_pass_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pass == (error_code == ERR_NONE)))
    else $error("pass flag disagrees with error code");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code <= ERR_SEQ))
    else $error("error code out of range");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind frame_stream_pattern_checker_core fspc_checker u_fspc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pass       (pass),
  .error_code (error_code)
);

`default_nettype wire
